### sv/spit_pkg.sv
// Shared types, widths and defaults for the sparse pattern index table.
package spit_pkg;

   localparam int FIELD_W         = 16;
   localparam int ENTRY_W         = 2 * FIELD_W;
   localparam int POS_W           = 10;
   localparam int STATUS_W        = 3;
   localparam int COUNT_OUT_W     = 11;
   localparam int EXTENT_W        = FIELD_W + 1;
   localparam int CMD_W           = 2;
   localparam int DEF_TABLE_DEPTH = 1024;
   localparam int DEF_INDEX_WIDTH = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_READ   = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_FILTERED     = 3'd1,
      ST_FULL         = 3'd2,
      ST_NOT_FOUND    = 3'd3,
      ST_OUT_OF_RANGE = 3'd4
   } status_type;

   typedef struct packed {
      logic       load_req;
      logic       ext_update;
      logic       clear_tbl;
      logic       search_init;
      logic       search_rd;
      logic       search_step;
      logic       read_pos;
      logic       shift_init;
      logic       shift_step;
      logic       place;
      logic       set_res;
      status_type res_status;
      logic       res_fpos_en;
      logic       res_data_en;
      logic       rsp_load;
   } ctl_type;

   typedef struct packed {
      logic filter_drop;
      logic search_open;
      logic key_hit;
      logic full;
      logic pos_ok;
      logic shift_last;
      logic rsp_free;
   } stat_type;

endpackage

### sv/spit_datapath.sv
// Datapath: pair memory, search bounds, shift pointer, counters and result registers.
module spit_datapath
   import spit_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctl_type                ctl,
   output stat_type               stat,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   input  logic [FIELD_W-1:0]     req_row,
   input  logic [FIELD_W-1:0]     req_col,
   input  logic [POS_W-1:0]       req_position,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [POS_W-1:0]       rsp_found_position,
   output logic [FIELD_W-1:0]     rsp_row_out,
   output logic [FIELD_W-1:0]     rsp_col_out,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output logic [EXTENT_W-1:0]    rsp_rows_in_use,
   output logic [EXTENT_W-1:0]    rsp_cols_in_use
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam logic [FIELD_W-1:0] IDX_MASK = (INDEX_WIDTH >= FIELD_W) ?
      {FIELD_W{1'b1}} : FIELD_W'((64'd1 << INDEX_WIDTH) - 64'd1);

   logic [ENTRY_W-1:0]     entry_ff [TABLE_DEPTH];
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ENTRY_W-1:0]     wr_data;

   logic [ENTRY_W-1:0]     key_ff, key_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [EXTENT_W-1:0]    row_ext_ff, row_ext_in;
   logic [EXTENT_W-1:0]    col_ext_ff, col_ext_in;
   logic                   lower_only_ff, lower_only_in;
   logic [CNT_W-1:0]       lo_ff, lo_in;
   logic [CNT_W-1:0]       hi_ff, hi_in;
   logic [CNT_W-1:0]       dst_ff, dst_in;
   logic                   pend_ff, pend_in;
   status_type             res_status_ff, res_status_in;
   logic [POS_W-1:0]       res_fpos_ff, res_fpos_in;
   logic [FIELD_W-1:0]     res_row_ff, res_row_in;
   logic [FIELD_W-1:0]     res_col_ff, res_col_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]       rsp_fpos_ff, rsp_fpos_in;
   logic [FIELD_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [FIELD_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [EXTENT_W-1:0]    rsp_rext_ff, rsp_rext_in;
   logic [EXTENT_W-1:0]    rsp_cext_ff, rsp_cext_in;

   logic [FIELD_W-1:0]     key_row;
   logic [FIELD_W-1:0]     key_col;
   logic [EXTENT_W-1:0]    row_plus;
   logic [EXTENT_W-1:0]    col_plus;
   logic [CNT_W-1:0]       mid;
   logic [CNT_W-1:0]       dst_nx;
   logic                   shift_go;

   assign key_row  = key_ff[ENTRY_W-1:FIELD_W];
   assign key_col  = key_ff[FIELD_W-1:0];
   assign row_plus = {1'b0, key_row} + EXTENT_W'(1);
   assign col_plus = {1'b0, key_col} + EXTENT_W'(1);
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign dst_nx   = pend_ff ? dst_ff - CNT_W'(1) : dst_ff;
   assign shift_go = dst_nx > lo_ff;

   always_comb begin
      stat.filter_drop = lower_only_ff && (key_row < key_col);
      stat.search_open = lo_ff < hi_ff;
      stat.key_hit     = (lo_ff < count_ff) && (rd_data_ff == key_ff);
      stat.full        = count_ff == CNT_W'(TABLE_DEPTH);
      stat.pos_ok      = 32'(pos_ff) < 32'(count_ff);
      stat.shift_last  = !shift_go;
      stat.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ADDR_W'(lo_ff);
      wr_en   = 1'b0;
      wr_addr = ADDR_W'(lo_ff);
      wr_data = key_ff;
      if (ctl.search_rd) begin
         rd_en   = 1'b1;
         rd_addr = stat.search_open ? ADDR_W'(mid) : ADDR_W'(lo_ff);
      end
      if (ctl.read_pos) begin
         rd_en   = 1'b1;
         rd_addr = ADDR_W'(pos_ff);
      end
      if (ctl.shift_step) begin
         rd_en   = shift_go;
         rd_addr = ADDR_W'(dst_nx - CNT_W'(1));
         wr_en   = pend_ff;
         wr_addr = ADDR_W'(dst_ff);
         wr_data = rd_data_ff;
      end
      if (ctl.place) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_ff[rd_addr];
      end
   end

   always_comb begin
      key_in        = key_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      row_ext_in    = row_ext_ff;
      col_ext_in    = col_ext_ff;
      lower_only_in = lower_only_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      dst_in        = dst_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_fpos_in   = res_fpos_ff;
      res_row_in    = res_row_ff;
      res_col_in    = res_col_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_rext_in   = rsp_rext_ff;
      rsp_cext_in   = rsp_cext_ff;

      if (csr_write_enable) begin
         lower_only_in = csr_write_data;
      end
      if (ctl.load_req) begin
         key_in = {req_row & IDX_MASK, req_col & IDX_MASK};
         pos_in = req_position;
      end
      if (ctl.ext_update) begin
         if (row_plus > row_ext_ff) begin
            row_ext_in = row_plus;
         end
         if (col_plus > col_ext_ff) begin
            col_ext_in = col_plus;
         end
      end
      if (ctl.clear_tbl) begin
         count_in   = '0;
         row_ext_in = '0;
         col_ext_in = '0;
      end
      if (ctl.search_init) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (ctl.search_step) begin
         if (rd_data_ff < key_ff) begin
            lo_in = mid + CNT_W'(1);
         end else begin
            hi_in = mid;
         end
      end
      if (ctl.shift_init) begin
         dst_in  = count_ff;
         pend_in = 1'b0;
      end
      if (ctl.shift_step) begin
         dst_in  = dst_nx;
         pend_in = shift_go;
      end
      if (ctl.place) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (ctl.set_res) begin
         res_status_in = ctl.res_status;
         res_fpos_in   = ctl.res_fpos_en ? POS_W'(lo_ff) : '0;
         res_row_in    = ctl.res_data_en ? rd_data_ff[ENTRY_W-1:FIELD_W] : '0;
         res_col_in    = ctl.res_data_en ? rd_data_ff[FIELD_W-1:0] : '0;
      end
      if (ctl.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_fpos_in   = res_fpos_ff;
         rsp_row_in    = res_row_ff;
         rsp_col_in    = res_col_ff;
         rsp_count_in  = COUNT_OUT_W'(count_ff);
         rsp_rext_in   = row_ext_ff;
         rsp_cext_in   = col_ext_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         row_ext_ff    <= '0;
         col_ext_ff    <= '0;
         lower_only_ff <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         row_ext_ff    <= row_ext_in;
         col_ext_ff    <= col_ext_in;
         lower_only_ff <= lower_only_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      dst_ff        <= dst_in;
      res_status_ff <= res_status_in;
      res_fpos_ff   <= res_fpos_in;
      res_row_ff    <= res_row_in;
      res_col_ff    <= res_col_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_rext_ff   <= rsp_rext_in;
      rsp_cext_ff   <= rsp_cext_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_row_out        = rsp_row_ff;
   assign rsp_col_out        = rsp_col_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_rows_in_use    = rsp_rext_ff;
   assign rsp_cols_in_use    = rsp_cext_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_place_count: assert property (@(posedge clock) disable iff (reset)
      ctl.place |=> count_ff == CNT_W'($past(count_ff) + CNT_W'(1)))
      else $error("place did not advance the entry count");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      ctl.search_step |=> lo_ff <= hi_ff)
      else $error("search bounds crossed");

endmodule

### sv/spit_controller.sv
// Controller: sequences insert, lookup, read and clear transactions over the datapath.
module spit_controller
   import spit_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [CMD_W-1:0] req_cmd,
   input  stat_type         stat,
   output ctl_type          ctl
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_SEARCH_RD,
      S_SEARCH_CMP,
      S_CHECK_CMP,
      S_READ_WAIT,
      S_SHIFT,
      S_PLACE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               cmd_in       = cmd_type'(req_cmd);
               state_in     = S_START;
            end
         end
         S_START: begin
            unique case (cmd_ff)
               CMD_INSERT: begin
                  ctl.ext_update = 1'b1;
                  if (stat.filter_drop) begin
                     ctl.set_res    = 1'b1;
                     ctl.res_status = ST_FILTERED;
                     state_in       = S_DONE;
                  end else begin
                     ctl.search_init = 1'b1;
                     state_in        = S_SEARCH_RD;
                  end
               end
               CMD_LOOKUP: begin
                  ctl.search_init = 1'b1;
                  state_in        = S_SEARCH_RD;
               end
               CMD_READ: begin
                  if (stat.pos_ok) begin
                     ctl.read_pos = 1'b1;
                     state_in     = S_READ_WAIT;
                  end else begin
                     ctl.set_res    = 1'b1;
                     ctl.res_status = ST_OUT_OF_RANGE;
                     state_in       = S_DONE;
                  end
               end
               CMD_CLEAR: begin
                  ctl.clear_tbl  = 1'b1;
                  ctl.set_res    = 1'b1;
                  ctl.res_status = ST_OK;
                  state_in       = S_DONE;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SEARCH_RD: begin
            ctl.search_rd = 1'b1;
            state_in      = stat.search_open ? S_SEARCH_CMP : S_CHECK_CMP;
         end
         S_SEARCH_CMP: begin
            ctl.search_step = 1'b1;
            state_in        = S_SEARCH_RD;
         end
         S_CHECK_CMP: begin
            if (stat.key_hit) begin
               ctl.set_res     = 1'b1;
               ctl.res_status  = ST_OK;
               ctl.res_fpos_en = 1'b1;
               state_in        = S_DONE;
            end else if (cmd_ff == CMD_LOOKUP) begin
               ctl.set_res    = 1'b1;
               ctl.res_status = ST_NOT_FOUND;
               state_in       = S_DONE;
            end else if (stat.full) begin
               ctl.set_res    = 1'b1;
               ctl.res_status = ST_FULL;
               state_in       = S_DONE;
            end else begin
               ctl.shift_init = 1'b1;
               state_in       = S_SHIFT;
            end
         end
         S_SHIFT: begin
            ctl.shift_step = 1'b1;
            if (stat.shift_last) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            ctl.place       = 1'b1;
            ctl.set_res     = 1'b1;
            ctl.res_status  = ST_OK;
            ctl.res_fpos_en = 1'b1;
            state_in        = S_DONE;
         end
         S_READ_WAIT: begin
            ctl.set_res     = 1'b1;
            ctl.res_status  = ST_OK;
            ctl.res_data_en = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cmd_ff   <= CMD_INSERT;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_START)
      else $error("accepted transaction did not start");

   a_shift_only_insert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> cmd_ff == CMD_INSERT)
      else $error("table shift outside an insert");

endmodule

### sv/sparse_pattern_index_table.sv
// Top level of the sparse pattern index table: sorted (row, col) pair store.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   cmd, row, col, position
//   rsp      out        rsp_valid / rsp_stall   status, found_position, row_out, col_out,
//                                               entry_count, rows_in_use, cols_in_use
//   csr      in         csr_write_enable        csr_write_data (lower_only)
//
// One transaction at a time; every probe of the single-read-port pair memory is an address
// followed by registered data. Lookup and insert binary-search the stored pairs; an insert
// of a new pair then moves the entries above the insert point up, one entry per cycle.
// Synchronous active-high reset clears the count, extents and lower_only; the memory is
// not cleared. req is taken again while a finished rsp is still stalled.
module sparse_pattern_index_table
   import spit_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [FIELD_W-1:0]     req_row,
   input  logic [FIELD_W-1:0]     req_col,
   input  logic [POS_W-1:0]       req_position,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [POS_W-1:0]       rsp_found_position,
   output logic [FIELD_W-1:0]     rsp_row_out,
   output logic [FIELD_W-1:0]     rsp_col_out,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output logic [EXTENT_W-1:0]    rsp_rows_in_use,
   output logic [EXTENT_W-1:0]    rsp_cols_in_use
);

   ctl_type  ctl;
   stat_type stat;

   spit_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .stat      (stat),
      .ctl       (ctl)
   );

   spit_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .stat               (stat),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_row_out        (rsp_row_out),
      .rsp_col_out        (rsp_col_out),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_rows_in_use    (rsp_rows_in_use),
      .rsp_cols_in_use    (rsp_cols_in_use)
   );

endmodule
